// File: sv/mbrs_pkg.sv
package mbrs_pkg;

	// bank size default
	localparam int unsigned REG_COUNT_DEF = 32;

	// function codes
	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_READ_INPUT   = 8'h04;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

	// exception flag and codes
	localparam logic [7:0] EXC_FLAG         = 8'h80;
	localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
	localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;
	localparam logic [7:0] EXC_ILLEGAL_DATA = 8'h03;

	// request shape limits
	localparam logic [7:0]  REQ_LEN = 8'd5;
	localparam logic [15:0] MAX_QTY = 16'd125;

	typedef struct packed {
		logic [7:0]  pdu_length;
		logic [7:0]  function_code;
		logic [15:0] address;
		logic [15:0] operand;
	} req_t;

	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       second_valid;
		logic       last;
	} rsp_t;

endpackage

// File: sv/modbus_register_slave_pdu.sv
// channel    ports                 handshake
// request    start, busy, req      taken when start && !busy
// response   strobe, rsp           one pair per cycle while strobe is high
//
// a request passes through decode, then sends its pairs on back-to-back cycles
// read: a header pair, then one data pair per register (one bank read per cycle, one read port)
// write: a header pair and two echo pairs; exception: one pair; empty request: no pairs
// busy stays high until the last pair is registered; the receiver cannot stall
// reset clears the sequencer and the bank's written flags, so the bank reads zero
module modbus_register_slave_pdu #(
	parameter int unsigned REG_COUNT = mbrs_pkg::REG_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mbrs_pkg::req_t req,
	output logic          strobe,
	output mbrs_pkg::rsp_t rsp
);

	localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int unsigned CW = $clog2(REG_COUNT + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_ECHO2,
		ST_ECHO3
	} state_t;

	state_t         state_q;
	mbrs_pkg::req_t req_q;
	logic [AW-1:0]  idx_q;
	logic [CW-1:0]  cnt_q;
	logic           strobe_q;
	mbrs_pkg::rsp_t rsp_q;

	logic           is_read;
	logic           is_write;
	logic           range_err;
	logic           req_ok;
	logic [7:0]     exc_code;
	logic [16:0]    span;
	logic           bank_wr_en;
	logic           bank_rd_en;
	logic [AW-1:0]  bank_rd_addr;
	logic [15:0]    bank_rd_data;

	// shared compare unit: end of read span or write address against bank size
	always_comb begin
		span = 17'({1'b0, req_q.address}) +
			((req_q.function_code == mbrs_pkg::FC_WRITE_SINGLE) ? 17'd1 :
			17'({1'b0, req_q.operand}));
		range_err = span > 17'(REG_COUNT);
	end

	// request decode
	always_comb begin
		is_read  = req_q.function_code inside {mbrs_pkg::FC_READ_HOLDING,
			mbrs_pkg::FC_READ_INPUT};
		is_write = req_q.function_code == mbrs_pkg::FC_WRITE_SINGLE;
		req_ok   = 1'b0;
		exc_code = mbrs_pkg::EXC_ILLEGAL_FUNC;
		if (is_read || is_write) begin
			if (req_q.pdu_length != mbrs_pkg::REQ_LEN) begin
				exc_code = mbrs_pkg::EXC_ILLEGAL_DATA;
			end else if (is_read && (req_q.operand == 16'd0 ||
				req_q.operand > mbrs_pkg::MAX_QTY)) begin
				exc_code = mbrs_pkg::EXC_ILLEGAL_DATA;
			end else if (range_err) begin
				exc_code = mbrs_pkg::EXC_ILLEGAL_ADDR;
			end else begin
				req_ok = 1'b1;
			end
		end
	end

	// bank port control
	always_comb begin
		bank_wr_en   = (state_q == ST_CHECK) && is_write && req_ok;
		bank_rd_en   = 1'b0;
		bank_rd_addr = idx_q;
		if (state_q == ST_CHECK) begin
			bank_rd_en   = is_read && req_ok;
			bank_rd_addr = req_q.address[AW-1:0];
		end else if (state_q == ST_READ) begin
			bank_rd_en = cnt_q != CW'(1);
		end
	end

	mbrs_regbank #(
		.REG_COUNT(REG_COUNT)
	) u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bank_wr_en),
		.wr_addr (req_q.address[AW-1:0]),
		.wr_data (req_q.operand),
		.rd_en   (bank_rd_en),
		.rd_addr (bank_rd_addr),
		.rd_data (bank_rd_data)
	);

	// sequencer with registered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			req_q    <= '0;
			idx_q    <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			rsp_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && req.pdu_length != 8'd0) begin
						req_q   <= req;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					strobe_q <= 1'b1;
					if (!req_ok) begin
						rsp_q   <= '{first_byte: req_q.function_code | mbrs_pkg::EXC_FLAG,
							second_byte: exc_code, second_valid: 1'b1, last: 1'b1};
						state_q <= ST_IDLE;
					end else if (is_read) begin
						rsp_q   <= '{first_byte: req_q.function_code,
							second_byte: {req_q.operand[6:0], 1'b0},
							second_valid: 1'b1, last: 1'b0};
						idx_q   <= req_q.address[AW-1:0] + AW'(1);
						cnt_q   <= req_q.operand[CW-1:0];
						state_q <= ST_READ;
					end else begin
						rsp_q   <= '{first_byte: req_q.function_code,
							second_byte: req_q.address[15:8],
							second_valid: 1'b1, last: 1'b0};
						state_q <= ST_ECHO2;
					end
				end
				ST_READ: begin
					strobe_q <= 1'b1;
					rsp_q    <= '{first_byte: bank_rd_data[15:8],
						second_byte: bank_rd_data[7:0], second_valid: 1'b1,
						last: cnt_q == CW'(1)};
					idx_q    <= idx_q + AW'(1);
					cnt_q    <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ECHO2: begin
					strobe_q <= 1'b1;
					rsp_q    <= '{first_byte: req_q.address[7:0],
						second_byte: req_q.operand[15:8], second_valid: 1'b1,
						last: 1'b0};
					state_q  <= ST_ECHO3;
				end
				ST_ECHO3: begin
					strobe_q <= 1'b1;
					rsp_q    <= '{first_byte: req_q.operand[7:0], second_byte: 8'h00,
						second_valid: 1'b0, last: 1'b1};
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	// an empty request produces nothing and leaves the block free
	a_empty_drop: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.pdu_length == 8'd0 |=> !busy && !strobe)
		else $error("empty request started work");

	// a non-empty request goes into decode with no pair yet
	a_start_decode: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.pdu_length != 8'd0 |=> busy && !strobe)
		else $error("request not taken into decode");

	// more pairs pending means the block must still be busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !rsp.last |-> busy)
		else $error("response cut short");

	// a half pair only closes a write echo
	a_half_pair: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !rsp.second_valid |-> rsp.last && rsp.second_byte == 8'h00)
		else $error("odd trailing byte misplaced");

endmodule

// File: sv/mbrs_regbank.sv
module mbrs_regbank #(
	parameter int unsigned REG_COUNT = mbrs_pkg::REG_COUNT_DEF,
	localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0]          mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [15:0]          rd_data_q;

	// storage array, registered read, unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= vld_q[rd_addr] ? mem[rd_addr] : 16'h0000;
		end
	end

	// per-entry written flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule
